// ===== rtl/core/tpti_pkg.sv =====
// ----------------------------------------------------------------------------
// tpti_pkg
// Shared constants, codes and types of the three-point table interpolator.
// ----------------------------------------------------------------------------
package tpti_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Numerator and denominator width of the rounding divider
  localparam int DIV_W     = 128;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Input word kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_BELOW  = 3'd0;
  localparam logic [2:0] STAT_ABOVE  = 3'd1;
  localparam logic [2:0] STAT_EXACT  = 3'd2;
  localparam logic [2:0] STAT_LINEAR = 3'd3;
  localparam logic [2:0] STAT_PARAB  = 3'd4;
  localparam logic [2:0] STAT_EMPTY  = 3'd5;

  // Divider result
  typedef struct packed {
    logic        done;
    logic        sat;
    logic [31:0] value;
  } div_res_t;

endpackage

// ===== rtl/core/tpti_div.sv =====
// ----------------------------------------------------------------------------
// tpti_div
// Bit-serial restoring divider: signed 128-bit numerator by a positive
// denominator, rounded to nearest (ties away from zero), saturated to 32 bits.
// ----------------------------------------------------------------------------
module tpti_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tpti_pkg::DIV_W-1:0]  num_i,
  input  logic [tpti_pkg::DIV_W-1:0]  den_i,
  output tpti_pkg::div_res_t          res_o
);
  import tpti_pkg::*;

  localparam int QW = 34;

  logic                 busy_q, rnd_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 neg_q, ovf_q, sat_q;
  logic [DIV_W-1:0]     n_q, r_q, den_q;
  logic [QW-1:0]        q_q;
  logic [31:0]          value_q;

  logic [DIV_W:0]       rs, diff, r2;
  logic                 ge, up, over;
  logic [QW:0]          qr, lim;

  // One quotient bit per cycle
  always_comb begin
    rs   = {r_q, n_q[DIV_W-1]};
    diff = rs - {1'b0, den_q};
    ge   = rs >= {1'b0, den_q};
    r2   = {r_q, 1'b0};
    up   = r2 >= {1'b0, den_q};
    qr   = {1'b0, q_q} + (QW+1)'(up);
    lim  = neg_q ? (QW+1)'(33'h080000000) : (QW+1)'(33'h07FFFFFFF);
    over = ovf_q || (qr > lim);
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q && !rnd_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          rnd_q <= 1'b1;
        end
      end else if (busy_q) begin
        busy_q <= 1'b0;
        rnd_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[DIV_W-1];
      n_q   <= num_i[DIV_W-1] ? (~num_i + DIV_W'(1)) : num_i;
      den_q <= den_i;
      r_q   <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q && !rnd_q) begin
      n_q <= {n_q[DIV_W-2:0], 1'b0};
      r_q <= ge ? diff[DIV_W-1:0] : rs[DIV_W-1:0];
      q_q <= {q_q[QW-2:0], ge};
      if (q_q[QW-1]) begin
        ovf_q <= 1'b1;
      end
    end else if (busy_q) begin
      sat_q <= over;
      if (over) begin
        value_q <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        value_q <= neg_q ? (~qr[31:0] + 32'd1) : qr[31:0];
      end
    end
  end

  assign res_o = '{done: done_q, sat: sat_q, value: value_q};

endmodule

// ===== rtl/core/three_point_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// three_point_table_interpolator
// Point table in two block memories, binary search, linear or parabolic
// interpolation on a shared 32x32 multiplier and a serial rounding divider.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                          | tuser
//  s_axis   | in  | point_w, point_y, query_w      | kind
//  m_axis   | out | value                          | status, saturated
//
//  Load and clear words are taken in the idle state. A query answered from
//  the end points goes straight to its result; one that interpolates runs
//  up to 10 search steps, then fetches its ordinates, forms the products on
//  the multiplier and divides, the divider setting the pace. One word is
//  worked on at a time. Reset empties the table at once; memories need no
//  clearing. A stalled output holds its word; the next query waits only for
//  the output register.
// ----------------------------------------------------------------------------
module three_point_table_interpolator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // point_w[31:0], point_y[63:32], query_w[95:64]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // value[31:0]
  output logic [3:0]  m_axis_tuser    // status[2:0], saturated[3]
);
  import tpti_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_PREP  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_RES   = 3'd7;

  logic [2:0]        state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [31:0]       first_w_q, last_w_q, last_y_q;
  logic [31:0]       w_q, lo_w_q, hi_w_q;
  logic [ADDR_W-1:0] lo_q, hi_q, mid_q;
  logic              exact_q, lin_q;
  logic [1:0]        fidx_q, fend_q, fcap_q;
  logic              fval_q;
  logic [31:0]       y_q [3];
  logic [31:0]       a_q, h_q, x_q;
  logic [1:0]        term_q;
  logic [2:0]        op_q;
  logic              ph_q;
  logic [63:0]       m_q, p_q, k_q;
  logic [DIV_W-1:0]  acc_q, den_q;
  logic              div_start_q;
  logic [31:0]       res_val_q, out_val_q;
  logic [2:0]        res_st_q, out_st_q;
  logic              res_sat_q, out_sat_q, out_valid_q;

  logic [31:0]       in_pw, in_py, in_qw;
  logic [1:0]        in_kind;
  logic              accept, mem_we, out_load;
  logic [ADDR_W-1:0] span, mid, abs_ra, ord_ra;
  logic              more;
  logic [31:0]       abs_rd_q, ord_rd_q;
  logic [31:0]       abs_mem [TABLE_DEPTH];
  logic [31:0]       ord_mem [TABLE_DEPTH];

  logic [31:0]       xa, s, hx, y_sel, k_sel, pa, pb, ym, opa, opb;
  logic              flip, neg;
  logic [2:0]        last_op;
  logic [63:0]       prod;
  logic [DIV_W-1:0]  addend;
  div_res_t          div_res;

  // Unpack the input word
  assign in_pw   = s_axis_tdata[31:0];
  assign in_py   = s_axis_tdata[63:32];
  assign in_qw   = s_axis_tdata[95:64];
  assign in_kind = s_axis_tuser;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mem_we = accept && (in_kind == KIND_LOAD) && (cnt_q < CNT_W'(TABLE_DEPTH)) &&
                  ((cnt_q == CNT_W'(0)) || (in_pw > last_w_q));
  assign out_load = (state_q == S_RES) && (!out_valid_q || m_axis_tready);

  // Search midpoint
  assign span = hi_q - lo_q;
  assign more = span > ADDR_W'(1);
  assign mid  = lo_q + (span >> 1);

  // Read addresses
  always_comb begin
    abs_ra = (state_q == S_SRCH) ? mid : (lo_q - ADDR_W'(1));
    case (fidx_q)
      2'd0:    ord_ra = lo_q - ADDR_W'(1);
      2'd1:    ord_ra = lo_q;
      default: ord_ra = hi_q;
    endcase
  end

  // Point memories
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      abs_mem[cnt_q[ADDR_W-1:0]] <= in_pw;
      ord_mem[cnt_q[ADDR_W-1:0]] <= in_py;
    end
    abs_rd_q <= abs_mem[abs_ra];
    ord_rd_q <= ord_mem[ord_ra];
  end

  // Operands of each product term
  always_comb begin
    xa   = x_q + a_q;
    s    = a_q + h_q;
    hx   = h_q - x_q;
    flip = 1'b0;
    if (lin_q) begin
      k_sel = 32'd1;
      pb    = 32'd1;
      if (term_q == 2'd0) begin
        y_sel = y_q[1];
        pa    = hx;
      end else begin
        y_sel = y_q[2];
        pa    = x_q;
      end
    end else begin
      case (term_q)
        2'd0: begin
          y_sel = y_q[0]; k_sel = h_q; pa = x_q; pb = hx; flip = 1'b1;
        end
        2'd1: begin
          y_sel = y_q[1]; k_sel = s; pa = xa; pb = hx;
        end
        default: begin
          y_sel = y_q[2]; k_sel = a_q; pa = x_q; pb = xa;
        end
      endcase
    end
    ym  = y_sel[31] ? (~y_sel + 32'd1) : y_sel;
    neg = y_sel[31] ^ flip;

    // Multiplier operand select
    if (term_q == 2'd3) begin
      last_op = 3'd2;
      case (op_q)
        3'd0:    begin opa = a_q;        opb = h_q; end
        3'd1:    begin opa = p_q[31:0];  opb = s;   end
        default: begin opa = p_q[63:32]; opb = s;   end
      endcase
    end else begin
      last_op = 3'd5;
      case (op_q)
        3'd0:    begin opa = pa;         opb = pb;         end
        3'd1:    begin opa = ym;         opb = k_sel;      end
        3'd2:    begin opa = k_q[31:0];  opb = p_q[31:0];  end
        3'd3:    begin opa = k_q[31:0];  opb = p_q[63:32]; end
        3'd4:    begin opa = k_q[63:32]; opb = p_q[31:0];  end
        default: begin opa = k_q[63:32]; opb = p_q[63:32]; end
      endcase
    end
    prod = opa * opb;

    // Weight of the partial product
    case (op_q)
      3'd3, 3'd4: addend = DIV_W'(m_q) << 32;
      3'd5:       addend = DIV_W'(m_q) << 64;
      default:    addend = DIV_W'(m_q);
    endcase
  end

  // Sequencer and table control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      fval_q      <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      term_q      <= '0;
      op_q        <= '0;
      ph_q        <= 1'b0;
      fidx_q      <= '0;
    end else begin
      fval_q      <= (state_q == S_FETCH);
      div_start_q <= 1'b0;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (mem_we) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
            if (in_kind == KIND_CLEAR) begin
              cnt_q <= '0;
            end
            if (in_kind == KIND_QUERY) begin
              if ((cnt_q == CNT_W'(0)) || (in_qw < first_w_q) || (in_qw >= last_w_q)) begin
                state_q <= S_RES;
              end else begin
                state_q <= S_SRCH;
              end
            end
          end
        end
        S_SRCH: begin
          if (more) begin
            state_q <= S_CMP;
          end else begin
            state_q <= S_FETCH;
            fidx_q  <= (lo_w_q == w_q || lo_q == ADDR_W'(0)) ? 2'd1 : 2'd0;
          end
        end
        S_CMP: state_q <= S_SRCH;
        S_FETCH: begin
          if (fidx_q == fend_q) begin
            state_q <= S_PREP;
          end else begin
            fidx_q <= fidx_q + 2'd1;
          end
        end
        S_PREP: begin
          state_q <= exact_q ? S_RES : S_MUL;
          term_q  <= '0;
          op_q    <= '0;
          ph_q    <= 1'b0;
        end
        S_MUL: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (op_q == last_op) begin
              op_q <= '0;
              if (term_q == 2'd3 || (lin_q && term_q == 2'd1)) begin
                state_q     <= S_DIV;
                div_start_q <= 1'b1;
              end else begin
                term_q <= term_q + 2'd1;
              end
            end else begin
              op_q <= op_q + 3'd1;
            end
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            state_q <= S_RES;
          end
        end
        S_RES: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    // Capture each fetched ordinate from the registered read of its memory
    if (fval_q) begin
      y_q[fcap_q] <= ord_rd_q;
    end
    fcap_q <= fidx_q;

    case (state_q)
      S_IDLE: begin
        if (mem_we) begin
          last_w_q <= in_pw;
          last_y_q <= in_py;
          if (cnt_q == CNT_W'(0)) begin
            first_w_q <= in_pw;
          end
        end
        w_q       <= in_qw;
        lo_q      <= '0;
        hi_q      <= ADDR_W'(cnt_q - CNT_W'(1));
        lo_w_q    <= first_w_q;
        hi_w_q    <= last_w_q;
        res_sat_q <= 1'b0;
        res_val_q <= '0;
        if (cnt_q == CNT_W'(0)) begin
          res_st_q <= STAT_EMPTY;
        end else if (in_qw < first_w_q) begin
          res_st_q <= STAT_BELOW;
        end else begin
          res_st_q  <= STAT_ABOVE;
          res_val_q <= last_y_q;
        end
      end
      S_SRCH: begin
        mid_q   <= mid;
        exact_q <= (lo_w_q == w_q);
        lin_q   <= (lo_q == ADDR_W'(0));
        fend_q  <= (lo_w_q == w_q) ? 2'd1 : 2'd2;
      end
      S_CMP: begin
        if (abs_rd_q <= w_q) begin
          lo_q   <= mid_q;
          lo_w_q <= abs_rd_q;
        end else begin
          hi_q   <= mid_q;
          hi_w_q <= abs_rd_q;
        end
      end
      S_PREP: begin
        res_val_q <= ord_rd_q;
        res_st_q  <= exact_q ? STAT_EXACT : (lin_q ? STAT_LINEAR : STAT_PARAB);
        res_sat_q <= 1'b0;
        a_q       <= lo_w_q - abs_rd_q;
        h_q       <= hi_w_q - lo_w_q;
        x_q       <= w_q - lo_w_q;
        den_q     <= lin_q ? DIV_W'(hi_w_q - lo_w_q) : '0;
        acc_q     <= '0;
      end
      S_MUL: begin
        if (!ph_q) begin
          m_q <= prod;
        end else if (term_q == 2'd3) begin
          case (op_q)
            3'd0:    p_q   <= m_q;
            3'd1:    den_q <= DIV_W'(m_q);
            default: den_q <= den_q + (DIV_W'(m_q) << 32);
          endcase
        end else begin
          case (op_q)
            3'd0:    p_q   <= m_q;
            3'd1:    k_q   <= m_q;
            default: acc_q <= neg ? (acc_q - addend) : (acc_q + addend);
          endcase
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          res_val_q <= div_res.value;
          res_sat_q <= div_res.sat;
        end
      end
      default: begin
      end
    endcase

    // Output register
    if (out_load) begin
      out_val_q <= res_val_q;
      out_st_q  <= res_st_q;
      out_sat_q <= res_sat_q;
    end
  end

  tpti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (acc_q),
    .den_i   (den_q),
    .res_o   (div_res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = {out_sat_q, out_st_q};

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("point count beyond table depth");

  a_mid_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (mid_q > lo_q && mid_q < hi_q))
    else $error("search probe outside its interval");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == S_RES))
    else $error("output word raised without a result");

endmodule

// ===== tb/sv/three_point_table_interpolator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_point_table_interpolator_checker
// Watches both stream channels of the interpolator. It keeps its own copy of
// the point table and works out the answer of every accepted query exactly,
// in wide integers. It then compares each output word with the oldest
// pending answer.
// ----------------------------------------------------------------------------
module three_point_table_interpolator_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // point_w[31:0], point_y[63:32], query_w[95:64]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // value[31:0]
  input  logic [3:0]  m_axis_tuser,   // status[2:0], saturated[3]
  output int          fail_count_o,
  output int          pending_o
);
  import tpti_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
    logic        sat;
  } answer_t;

  logic [31:0] table_w [TABLE_DEPTH];
  logic [31:0] table_y [TABLE_DEPTH];
  int          n_points;
  answer_t     answer_q [$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = answer_q.size();

  function automatic logic signed [129:0] sx(input logic [31:0] v);
    return {{98{v[31]}}, v};
  endfunction

  function automatic logic signed [129:0] ux(input logic [63:0] v);
    return {66'b0, v};
  endfunction

  // Round to nearest, ties away from zero, then clamp to 32 bits
  function automatic answer_t round_clamp(input logic signed [129:0] num,
                                          input logic signed [129:0] den,
                                          input logic [2:0] status);
    answer_t     r;
    logic        neg;
    logic [129:0] mag;
    logic [129:0] quo;
    neg = num < 0;
    mag = neg ? -num : num;
    quo = ((mag << 1) + den) / (den << 1);
    r.status = status;
    r.sat    = 1'b0;
    if (neg) begin
      if (quo > 130'h80000000) begin
        r.sat   = 1'b1;
        r.value = 32'h80000000;
      end else begin
        r.value = -quo[31:0];
      end
    end else begin
      if (quo > 130'h7FFFFFFF) begin
        r.sat   = 1'b1;
        r.value = 32'h7FFFFFFF;
      end else begin
        r.value = quo[31:0];
      end
    end
    return r;
  endfunction

  // Answer a query against the mirrored table
  function automatic answer_t interpolate(input logic [31:0] w);
    answer_t r;
    int lo, hi, mid;
    logic [63:0] a, h, x;
    logic signed [129:0] num, den;
    r = '0;
    if (n_points == 0) begin
      r.status = STAT_EMPTY;
    end else if (w < table_w[0]) begin
      r.status = STAT_BELOW;
    end else if (w >= table_w[n_points-1]) begin
      r.status = STAT_ABOVE;
      r.value  = table_y[n_points-1];
    end else begin
      lo = 0;
      hi = n_points - 1;
      while (hi - lo > 1) begin
        mid = lo + (hi - lo) / 2;
        if (table_w[mid] <= w) lo = mid;
        else hi = mid;
      end
      if (table_w[lo] == w) begin
        r.status = STAT_EXACT;
        r.value  = table_y[lo];
      end else if (lo == 0) begin
        num = sx(table_y[0]) * ux({32'b0, table_w[1]} - {32'b0, w})
            + sx(table_y[1]) * ux({32'b0, w} - {32'b0, table_w[0]});
        den = ux({32'b0, table_w[1]} - {32'b0, table_w[0]});
        r = round_clamp(num, den, STAT_LINEAR);
      end else begin
        a = {32'b0, table_w[lo]} - {32'b0, table_w[lo-1]};
        h = {32'b0, table_w[hi]} - {32'b0, table_w[lo]};
        x = {32'b0, w} - {32'b0, table_w[lo]};
        num = -(sx(table_y[lo-1]) * ux(h) * ux(x * (h - x)))
            + sx(table_y[lo]) * ux(a + h) * ux((x + a) * (h - x))
            + sx(table_y[hi]) * ux(a) * ux(x * (x + a));
        den = ux(a * h) * ux(a + h);
        r = round_clamp(num, den, STAT_PARAB);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  initial begin
    fails    = 0;
    n_points = 0;
  end

  // Mirror the table and queue the answer of every accepted query
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      case (s_axis_tuser)
        KIND_LOAD: begin
          if (n_points < TABLE_DEPTH &&
              (n_points == 0 || s_axis_tdata[31:0] > table_w[n_points-1])) begin
            table_w[n_points] = s_axis_tdata[31:0];
            table_y[n_points] = s_axis_tdata[63:32];
            n_points++;
          end
        end
        KIND_QUERY: answer_q = {answer_q, interpolate(s_axis_tdata[95:64])};
        KIND_CLEAR: n_points = 0;
        default: ;
      endcase
    end
  end

  // Compare each output word with the oldest answer
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, 32'h0);
      end else begin
        want = answer_q.pop_front();
        if (m_axis_tdata !== want.value)
          report_mismatch("value", m_axis_tdata, want.value);
        if (m_axis_tuser[2:0] !== want.status)
          report_mismatch("status", {29'b0, m_axis_tuser[2:0]}, {29'b0, want.status});
        if (m_axis_tuser[3] !== want.sat)
          report_mismatch("saturated", {31'b0, m_axis_tuser[3]}, {31'b0, want.sat});
      end
    end
  end

endmodule

// ===== tb/sv/three_point_table_interpolator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_point_table_interpolator_tb
// Drives load, query and clear words into the interpolator with random gaps
// and output stalls. A checker beside the block predicts every answer, and
// this module gives the verdict.
// ----------------------------------------------------------------------------
module three_point_table_interpolator_tb;
  import tpti_pkg::*;

  localparam logic [1:0] KIND_IGNORED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // point_w[31:0], point_y[63:32], query_w[95:64]
  logic [1:0]  s_axis_tuser;   // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // value[31:0]
  logic [3:0]  m_axis_tuser;   // status[2:0], saturated[3]

  int          fail_count;
  int          pending;
  int          words_sent;
  bit          quiet;
  bit          stall_done;

  // Abscissas the block should hold, tracked to build sequences
  logic [31:0] held_w [$];

  three_point_table_interpolator uut (.*);

  three_point_table_interpolator_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Send one word and return at the edge that accepts it
  task automatic send_word(input logic [1:0] kind, input logic [31:0] pw,
                           input logic [31:0] py, input logic [31:0] qw);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {qw, py, pw};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    words_sent++;
    if (kind == KIND_LOAD && held_w.size() < TABLE_DEPTH &&
        (held_w.size() == 0 || pw > held_w[$]))
      held_w = {held_w, pw};
    if (kind == KIND_CLEAR) held_w.delete();
  endtask

  task automatic load_point(input logic [31:0] pw, input logic [31:0] py);
    send_word(KIND_LOAD, pw, py, $urandom);
  endtask

  task automatic query_at(input logic [31:0] qw);
    send_word(KIND_QUERY, $urandom, $urandom, qw);
  endtask

  function automatic logic [31:0] pick_ordinate();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 8) << 16;
      default: return $urandom;
    endcase
  endfunction

  // Pick a query abscissa around the held points
  function automatic logic [31:0] pick_query();
    int k;
    logic [31:0] lo_w, hi_w;
    if (held_w.size() == 0) return $urandom;
    k = $urandom_range(0, held_w.size() - 1);
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return held_w[k];
      3: return $urandom;
      4: return held_w[0] - $urandom_range(1, 3);
      default: begin
        lo_w = held_w[k];
        hi_w = (k + 1 < held_w.size()) ? held_w[k+1] : held_w[k] + 32'd100;
        if (hi_w <= lo_w) return lo_w;
        return lo_w + ($urandom % (hi_w - lo_w));
      end
    endcase
  endfunction

  // Output side: random stalls, one long hold-off, none at the end
  initial begin
    m_axis_tready <= 1'b0;
    stall_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!quiet && !stall_done && words_sent >= 400 && pending != 0) begin
        stall_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    logic [31:0] w;
    int n, m, random_words;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_LOAD;
    quiet         = 1'b0;
    words_sent    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty, single point, ignored loads, every status, extremes
    query_at(32'h00010000);
    load_point(32'h00010000, 32'h00050000);
    query_at(32'h0);
    query_at(32'h00010000);
    load_point(32'h00010000, 32'h12345678);
    load_point(32'h00008000, 32'h12345678);
    load_point(32'h00030000, 32'h7FFFFFFF);
    load_point(32'h00038000, 32'h80000000);
    load_point(32'hFFFFFFFF, 32'hFFFF0000);
    query_at(32'h00020000);
    query_at(32'h00030000);
    query_at(32'h00034000);
    query_at(32'h80000000);
    query_at(32'hFFFFFFFF);
    send_word(KIND_IGNORED, $urandom, $urandom, $urandom);
    send_word(KIND_CLEAR, $urandom, $urandom, $urandom);
    query_at(32'h00020000);
    // Parabola overshooting far past both ends of the range
    load_point(32'h0, 32'h7FFFFFFF);
    load_point(32'h1, 32'h80000000);
    load_point(32'h3E9, 32'h7FFFFFFF);
    query_at(32'h1F4);
    load_point(32'h7D0, 32'h80000000);
    query_at(32'h5DC);
    send_word(KIND_CLEAR, $urandom, $urandom, $urandom);

    // Fill the table to the last entry, then one more that is dropped
    for (int i = 0; i <= TABLE_DEPTH; i++) load_point(i * 32'h1000, $urandom);
    repeat (12) query_at($urandom_range(0, TABLE_DEPTH * 32'h1000 + 32'h800));
    query_at(32'hFFFFFFFF);

    // Random sequences: clear, load ascending points, query around them
    random_words = 0;
    while (random_words < 90) begin
      if (random_words > 50) quiet = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        send_word(KIND_CLEAR, $urandom, $urandom, $urandom);
        random_words++;
      end
      n = $urandom_range(1, 14);
      w = $urandom_range(0, 3) == 0 ? 32'h0 : $urandom >> $urandom_range(0, 31);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 19))
          0: load_point(held_w.size() > 0 ? held_w[$] : w, $urandom);
          1: send_word(KIND_IGNORED, $urandom, $urandom, $urandom);
          default: begin
            load_point(w, pick_ordinate());
            w = w + ($urandom_range(1, 2 ** $urandom_range(1, 26)));
          end
        endcase
        random_words++;
      end
      m = $urandom_range(2, 8);
      for (int i = 0; i < m; i++) begin
        query_at(pick_query());
        random_words++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[three_point_table_interpolator] OK");
    end else begin
      $display("[three_point_table_interpolator] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("[three_point_table_interpolator] ERROR");
    $finish;
  end

endmodule
